FILE: hdl/oto_pkg.sv
// Shared constants, types and arithmetic helpers for the object-to-window projection block.
package oto_pkg;

   localparam int COEF_W     = 32;
   localparam int FRAC_W     = 16;
   localparam int NUM_COEF   = 32;
   localparam int MV_COUNT   = NUM_COEF / 2;
   localparam int IDX_W      = 5;
   localparam int PROD_W     = 2 * COEF_W - FRAC_W;
   localparam int SUM_W      = PROD_W + 2;
   localparam int QUO_W      = COEF_W + FRAC_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int REM_W      = COEF_W + 1;
   localparam int NDC_W      = QUO_W + 1;
   localparam int BASE_W     = NDC_W + 1;
   localparam int SIZE_W     = 15;
   localparam int ORIGIN_W   = 16;
   localparam int TPROD_W    = BASE_W + SIZE_W + 1;
   localparam int WIDE_W     = TPROD_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_PROJECT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 2'd3;

   localparam logic signed [BASE_W-1:0] ONE_Q16 = BASE_W'(65536);

   typedef logic signed [COEF_W-1:0] q16_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [QUO_W-1:0] nq;
      logic             neg;
   } div_lane_type;

   typedef struct packed {
      q16_type win_x;
      q16_type win_y;
      q16_type win_z;
      logic    projected_ok;
   } result_type;

   // Exact Q16.16 product, floored back to Q16.16 scale.
   function automatic logic signed [PROD_W-1:0] mul_shift(input q16_type a, input q16_type b);
      logic signed [2*COEF_W-1:0] p;
      begin
         p = a * b;
         return p[2*COEF_W-1:FRAC_W];
      end
   endfunction

   function automatic q16_type sat32(input logic signed [WIDE_W-1:0] v);
      begin
         if (v[WIDE_W-1:COEF_W-1] == {(WIDE_W-COEF_W+1){v[COEF_W-1]}}) begin
            return v[COEF_W-1:0];
         end else if (v[WIDE_W-1]) begin
            return {1'b1, {(COEF_W-1){1'b0}}};
         end else begin
            return {1'b0, {(COEF_W-1){1'b1}}};
         end
      end
   endfunction

   // One restoring step of the unsigned magnitude divide.
   function automatic div_lane_type div_step(input div_lane_type x,
                                             input logic [COEF_W-1:0] d);
      logic [REM_W-1:0] sh;
      logic             q;
      div_lane_type     y;
      begin
         sh     = {x.rem[COEF_W-1:0], x.nq[QUO_W-1]};
         q      = (sh >= {1'b0, d});
         y.rem  = q ? (sh - {1'b0, d}) : sh;
         y.nq   = {x.nq[QUO_W-2:0], q};
         y.neg  = x.neg;
         return y;
      end
   endfunction

endpackage

FILE: hdl/oto_if.sv
// Request and response channel interfaces of the projection block.
interface oto_req_if;
   logic                           valid;
   logic                           ready;
   logic                           func;
   logic [oto_pkg::IDX_W-1:0]      coef_index;
   logic signed [oto_pkg::COEF_W-1:0] coef_value;
   logic signed [oto_pkg::COEF_W-1:0] obj_x;
   logic signed [oto_pkg::COEF_W-1:0] obj_y;
   logic signed [oto_pkg::COEF_W-1:0] obj_z;
   modport source (output valid, func, coef_index, coef_value, obj_x, obj_y, obj_z,
                   input ready);
   modport sink (input valid, func, coef_index, coef_value, obj_x, obj_y, obj_z,
                 output ready);
endinterface

interface oto_rsp_if;
   logic                           valid;
   logic                           ready;
   logic signed [oto_pkg::COEF_W-1:0] win_x;
   logic signed [oto_pkg::COEF_W-1:0] win_y;
   logic signed [oto_pkg::COEF_W-1:0] win_z;
   logic                           projected_ok;
   modport source (output valid, win_x, win_y, win_z, projected_ok, input ready);
   modport sink (input valid, win_x, win_y, win_z, projected_ok, output ready);
endinterface

FILE: hdl/object_to_window_projection.sv
// Pipelined object-to-window projection: two matrix transforms, divide and viewport.
//
//   channel    direction  carries
//   req_chan   in         load coefficient or project point request
//   rsp_chan   out        window x, y, depth and ok flag per projected point
//   csr_*      in         viewport origin and size writes
//
// A project request enters every cycle while the skid register is empty.
// The divide is a 48-step restoring divider, one quotient bit per stage.
// A load request waits while the first stage holds a point or the skid register is full.
// Reset clears valid bits and the viewport registers; coefficients must be loaded.
// A skid register behind the output register absorbs one response when rsp_chan stalls.
module object_to_window_projection (
   input  logic                                  clock,
   input  logic                                  reset,
   oto_req_if.sink                               req_chan,
   oto_rsp_if.source                             rsp_chan,
   input  logic                                  csr_we,
   input  logic [oto_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [oto_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int NS = oto_pkg::DIV_STEPS;

   oto_pkg::q16_type mat_ff [oto_pkg::NUM_COEF];

   logic signed [oto_pkg::ORIGIN_W-1:0] org_x_ff, org_y_ff;
   logic [oto_pkg::SIZE_W-1:0]          size_w_ff, size_h_ff;

   logic en;
   logic load_acc;
   logic proj_acc;

   oto_pkg::q16_type obj [3];

   logic                              v1_ff;
   logic signed [oto_pkg::PROD_W-1:0] s1_prod_ff [4][3];
   oto_pkg::q16_type                  s1_const_ff [4];

   logic             v2_ff;
   oto_pkg::q16_type eye_ff [4];

   logic                              v3_ff;
   logic signed [oto_pkg::PROD_W-1:0] s3_prod_ff [4][4];

   logic             v4_ff;
   oto_pkg::q16_type clip_ff [4];

   logic                       dv_ff [NS+1];
   logic                       wz_ff [NS+1];
   logic [oto_pkg::COEF_W-1:0] d_ff  [NS+1];
   oto_pkg::div_lane_type      lane_ff [NS+1][3];

   logic                               v6_ff;
   logic                               wz6_ff;
   logic signed [oto_pkg::TPROD_W-1:0] tx_ff, ty_ff;
   logic signed [oto_pkg::BASE_W-1:0]  tz_ff;

   oto_pkg::result_type res;
   oto_pkg::result_type out_ff, skid_ff;
   logic                out_v_ff, skid_v_ff;
   logic                take;

   // The pipeline moves whenever the skid register is free.
   assign en       = !skid_v_ff;
   assign req_chan.ready = en && (req_chan.func == oto_pkg::FUNC_PROJECT || !v1_ff);
   assign load_acc = req_chan.valid && req_chan.ready && req_chan.func == oto_pkg::FUNC_LOAD;
   assign proj_acc = req_chan.valid && req_chan.ready && req_chan.func == oto_pkg::FUNC_PROJECT;

   always_ff @(posedge clock) begin
      if (reset) begin
         org_x_ff  <= '0;
         org_y_ff  <= '0;
         size_w_ff <= '0;
         size_h_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            oto_pkg::CSR_ORIGIN_X: org_x_ff  <= csr_wdata;
            oto_pkg::CSR_ORIGIN_Y: org_y_ff  <= csr_wdata;
            oto_pkg::CSR_WIDTH:    size_w_ff <= csr_wdata[oto_pkg::SIZE_W-1:0];
            oto_pkg::CSR_HEIGHT:   size_h_ff <= csr_wdata[oto_pkg::SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc) begin
         mat_ff[req_chan.coef_index] <= req_chan.coef_value;
      end
   end

   assign obj[0] = req_chan.obj_x;
   assign obj[1] = req_chan.obj_y;
   assign obj[2] = req_chan.obj_z;

   // Valid bits of the transform stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= proj_acc;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   for (genvar r = 0; r < 4; r++) begin : g_rows
      // Modelview: w of the point is one, so column three adds unscaled.
      for (genvar c = 0; c < 3; c++) begin : g_mv
         always_ff @(posedge clock) begin
            if (en) begin
               s1_prod_ff[r][c] <= oto_pkg::mul_shift(mat_ff[c*4+r], obj[c]);
            end
         end
      end

      for (genvar c = 0; c < 4; c++) begin : g_pj
         always_ff @(posedge clock) begin
            if (en) begin
               s3_prod_ff[r][c] <= oto_pkg::mul_shift(mat_ff[oto_pkg::MV_COUNT+c*4+r],
                                                      eye_ff[c]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            s1_const_ff[r] <= mat_ff[12+r];
            eye_ff[r] <= oto_pkg::sat32(oto_pkg::WIDE_W'(
                  oto_pkg::SUM_W'(s1_prod_ff[r][0]) + oto_pkg::SUM_W'(s1_prod_ff[r][1])
                + oto_pkg::SUM_W'(s1_prod_ff[r][2]) + oto_pkg::SUM_W'(s1_const_ff[r])));
            clip_ff[r] <= oto_pkg::sat32(oto_pkg::WIDE_W'(
                  oto_pkg::SUM_W'(s3_prod_ff[r][0]) + oto_pkg::SUM_W'(s3_prod_ff[r][1])
                + oto_pkg::SUM_W'(s3_prod_ff[r][2]) + oto_pkg::SUM_W'(s3_prod_ff[r][3])));
         end
      end
   end

   // Divider setup: magnitudes of numerators and w, sign of each quotient.
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wz_ff[0] <= (clip_ff[3] == '0);
         d_ff[0]  <= clip_ff[3][oto_pkg::COEF_W-1] ? oto_pkg::COEF_W'(-clip_ff[3])
                                                   : clip_ff[3];
      end
   end

   for (genvar l = 0; l < 3; l++) begin : g_prep
      always_ff @(posedge clock) begin
         if (en) begin
            lane_ff[0][l].rem <= '0;
            lane_ff[0][l].nq  <= {(clip_ff[l][oto_pkg::COEF_W-1] ? oto_pkg::COEF_W'(-clip_ff[l])
                                                                 : clip_ff[l]),
                                  {oto_pkg::FRAC_W{1'b0}}};
            lane_ff[0][l].neg <= clip_ff[l][oto_pkg::COEF_W-1] ^ clip_ff[3][oto_pkg::COEF_W-1];
         end
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            wz_ff[k] <= wz_ff[k-1];
            d_ff[k]  <= d_ff[k-1];
         end
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         always_ff @(posedge clock) begin
            if (en) begin
               lane_ff[k][l] <= oto_pkg::div_step(lane_ff[k-1][l], d_ff[k-1]);
            end
         end
      end
   end

   // Signed quotients shifted into the viewport range.
   logic signed [oto_pkg::BASE_W-1:0] base [3];

   for (genvar l = 0; l < 3; l++) begin : g_base
      logic signed [oto_pkg::NDC_W-1:0] ndc;
      assign ndc = lane_ff[NS][l].neg ? -$signed({1'b0, lane_ff[NS][l].nq})
                                      :  $signed({1'b0, lane_ff[NS][l].nq});
      assign base[l] = oto_pkg::BASE_W'(ndc) + oto_pkg::ONE_Q16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= dv_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wz6_ff <= wz_ff[NS];
         tx_ff  <= oto_pkg::TPROD_W'(base[0]) *
                   oto_pkg::TPROD_W'($signed({1'b0, size_w_ff}));
         ty_ff  <= oto_pkg::TPROD_W'(base[1]) *
                   oto_pkg::TPROD_W'($signed({1'b0, size_h_ff}));
         tz_ff  <= base[2];
      end
   end

   always_comb begin
      if (wz6_ff) begin
         res = '0;
      end else begin
         res.win_x = oto_pkg::sat32(
                        $signed({{(oto_pkg::WIDE_W-oto_pkg::ORIGIN_W-oto_pkg::FRAC_W)
                                  {org_x_ff[oto_pkg::ORIGIN_W-1]}},
                                 org_x_ff, {oto_pkg::FRAC_W{1'b0}}})
                      + oto_pkg::WIDE_W'(tx_ff >>> 1));
         res.win_y = oto_pkg::sat32(
                        $signed({{(oto_pkg::WIDE_W-oto_pkg::ORIGIN_W-oto_pkg::FRAC_W)
                                  {org_y_ff[oto_pkg::ORIGIN_W-1]}},
                                 org_y_ff, {oto_pkg::FRAC_W{1'b0}}})
                      + oto_pkg::WIDE_W'(ty_ff >>> 1));
         res.win_z = oto_pkg::sat32(oto_pkg::WIDE_W'(tz_ff >>> 1));
         res.projected_ok = 1'b1;
      end
   end

   // Output register with a one-entry skid behind it.
   assign take = out_v_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (!out_v_ff || take) begin
         out_v_ff <= v6_ff;
      end else if (v6_ff) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (!out_v_ff || take) begin
         out_ff <= res;
      end else begin
         skid_ff <= res;
      end
   end

   assign rsp_chan.valid        = out_v_ff;
   assign rsp_chan.win_x        = out_ff.win_x;
   assign rsp_chan.win_y        = out_ff.win_y;
   assign rsp_chan.win_z        = out_ff.win_z;
   assign rsp_chan.projected_ok = out_ff.projected_ok;

`ifndef NO_ASSERTIONS
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff)
      else $error("skid entry held without a pending response");

   a_last_stage_lands: assert property (@(posedge clock) disable iff (reset)
      (v6_ff && en) |=> rsp_chan.valid)
      else $error("finished point did not reach the response register");

   a_zero_w_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.projected_ok) |->
         (rsp_chan.win_x == '0 && rsp_chan.win_y == '0 && rsp_chan.win_z == '0))
      else $error("failed projection carries nonzero coordinates");

   a_load_first_stage_empty: assert property (@(posedge clock) disable iff (reset)
      load_acc |=> !v2_ff)
      else $error("coefficient load overlapped a point between the transforms");
`endif

endmodule
